// ----- design/plsu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Phase lattice site update package
// Shared widths, Q24 constants, register indexes and elaboration helpers.
// ----------------------------------------------------------------------------
package plsu_pkg;

   localparam int ANGLE_WIDTH_DEF = 32;
   localparam int NOISE_BITS_DEF  = 20;

   localparam int FRAC      = 24;
   localparam int TRIG_W    = 28;
   localparam int RND_W     = 72;
   localparam int RED_STEPS = 4;
   localparam int SUM_W     = 38;
   localparam int PP_LO     = 18;
   localparam int DRIFT_W   = 46;
   localparam int CSR_W     = 32;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_COUPLING_X  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COUPLING_Y  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CURVATURE_X = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CURVATURE_Y = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_STEP   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_NOISE_GAIN  = 3'd5;

   localparam longint Q_TWO_PI  = 105414357;
   localparam longint Q_PI      = 52707179;
   localparam longint Q_HALF_PI = 26353589;

   localparam logic signed [TRIG_W-1:0] TWO_PI_T  = TRIG_W'(Q_TWO_PI);
   localparam logic signed [TRIG_W-1:0] PI_T      = TRIG_W'(Q_PI);
   localparam logic signed [TRIG_W-1:0] HALF_PI_T = TRIG_W'(Q_HALF_PI);
   localparam logic signed [TRIG_W-1:0] ONE_T     = TRIG_W'(longint'(1) << FRAC);
   localparam logic signed [TRIG_W-1:0] C3_T      = TRIG_W'(2796203);
   localparam logic signed [TRIG_W-1:0] C5_T      = TRIG_W'(139810);
   localparam logic signed [TRIG_W-1:0] C7_T      = TRIG_W'(3329);
   localparam logic signed [TRIG_W-1:0] C9_T      = TRIG_W'(46);

   function automatic int red_shift(input int w);
      int k;
      k = 0;
      while ((Q_TWO_PI << k) < (longint'(1) << w)) begin
         k = k + 1;
      end
      return k;
   endfunction

   function automatic int red_stages(input int w);
      return (red_shift(w) + RED_STEPS) / RED_STEPS;
   endfunction

   function automatic int red_width(input int w);
      return (w + 2 > TRIG_W) ? w + 2 : TRIG_W;
   endfunction

   function automatic int lane_stages(input int w);
      return red_stages(w) + 10;
   endfunction

   function automatic logic signed [RND_W-1:0] round_shift(
      input logic signed [RND_W-1:0] value, input int shift);
      logic signed [RND_W-1:0] bias;
      logic signed [RND_W-1:0] total;
      bias  = $signed(RND_W'(1) << (shift - 1)) - $signed(RND_W'(value[RND_W-1]));
      total = value + bias;
      return total >>> shift;
   endfunction

endpackage

// ----- design/plsu_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Phase lattice trig lane
// Reduces one angle difference modulo two pi and evaluates its sine and
// cosine with a pipelined Horner polynomial.
// ----------------------------------------------------------------------------
module plsu_lane import plsu_pkg::*; #(
   parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic [lane_stages(ANGLE_WIDTH)-1:0]  stage_en,
   input  logic signed [ANGLE_WIDTH-1:0]        center_angle,
   input  logic signed [ANGLE_WIDTH-1:0]        neighbor_angle,
   output logic signed [TRIG_W-1:0]             sin_value,
   output logic signed [TRIG_W-1:0]             cos_value
);

   localparam int RED_SHIFT  = red_shift(ANGLE_WIDTH);
   localparam int RED_STAGES = red_stages(ANGLE_WIDTH);
   localparam int RED_W      = red_width(ANGLE_WIDTH);
   localparam int ST_F1      = RED_STAGES + 1;
   localparam int ST_H0      = RED_STAGES + 3;
   localparam int PROD_W     = 2 * TRIG_W;
   localparam logic [RED_W-1:0] OFFSET   = RED_W'(Q_TWO_PI << RED_SHIFT);
   localparam logic [RED_W-1:0] TWO_PI_R = RED_W'(Q_TWO_PI);

   logic signed [ANGLE_WIDTH:0] diff;
   logic [RED_W-1:0]            red_ff [0:RED_STAGES];
   logic signed [TRIG_W-1:0]    xr;
   logic signed [TRIG_W-1:0]    arg_in [0:1];
   logic signed [TRIG_W-1:0]    arg_ff [0:1];
   logic signed [TRIG_W-1:0]    y_in   [0:1];
   logic signed [TRIG_W-1:0]    y_ff   [0:1];
   logic signed [PROD_W-1:0]    prod_in [0:5][0:1];
   logic signed [PROD_W-1:0]    prod_ff [0:5][0:1];
   logic signed [TRIG_W-1:0]    t_in   [2:5][0:1];
   logic signed [TRIG_W-1:0]    x2_in  [0:1];
   logic signed [TRIG_W-1:0]    x2_ff  [1:3][0:1];
   logic signed [TRIG_W-1:0]    yd_ff  [0:4][0:1];
   logic signed [TRIG_W-1:0]    s_in   [0:1];
   logic signed [TRIG_W-1:0]    s_ff   [0:1];

   assign diff = $signed({center_angle[ANGLE_WIDTH-1], center_angle})
               - $signed({neighbor_angle[ANGLE_WIDTH-1], neighbor_angle});

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         red_ff[0] <= $unsigned(RED_W'(diff)) + OFFSET;
      end
   end

   for (genvar r = 0; r < RED_STAGES; r++) begin : g_red
      logic [RED_W-1:0] step_out;
      always_comb begin : p_step
         logic [RED_W-1:0] x;
         int               k;
         x = red_ff[r];
         for (int j = 0; j < RED_STEPS; j++) begin
            k = RED_SHIFT - RED_STEPS * r - j;
            if (k >= 0) begin
               if (x >= (TWO_PI_R << k)) begin
                  x = x - (TWO_PI_R << k);
               end
            end
         end
         step_out = x;
      end
      always_ff @(posedge clock) begin
         if (stage_en[r+1]) begin
            red_ff[r+1] <= step_out;
         end
      end
   end

   assign xr = $signed(red_ff[RED_STAGES][TRIG_W-1:0]);

   always_comb begin
      arg_in[0] = (xr >= PI_T) ? xr - TWO_PI_T : xr;
      arg_in[1] = arg_in[0] + HALF_PI_T;
      if (arg_in[1] >= PI_T) begin
         arg_in[1] = arg_in[1] - TWO_PI_T;
      end
      for (int a = 0; a < 2; a++) begin
         if (arg_ff[a] > HALF_PI_T) begin
            y_in[a] = PI_T - arg_ff[a];
         end else if (arg_ff[a] < -HALF_PI_T) begin
            y_in[a] = -PI_T - arg_ff[a];
         end else begin
            y_in[a] = arg_ff[a];
         end
      end
   end

   always_comb begin
      for (int a = 0; a < 2; a++) begin
         prod_in[0][a] = y_ff[a] * y_ff[a];
         x2_in[a]      = TRIG_W'(round_shift(RND_W'(prod_ff[0][a]), FRAC));
         prod_in[1][a] = x2_in[a] * C9_T;
         t_in[2][a]    = C7_T - TRIG_W'(round_shift(RND_W'(prod_ff[1][a]), FRAC));
         prod_in[2][a] = x2_ff[1][a] * t_in[2][a];
         t_in[3][a]    = C5_T - TRIG_W'(round_shift(RND_W'(prod_ff[2][a]), FRAC));
         prod_in[3][a] = x2_ff[2][a] * t_in[3][a];
         t_in[4][a]    = C3_T - TRIG_W'(round_shift(RND_W'(prod_ff[3][a]), FRAC));
         prod_in[4][a] = x2_ff[3][a] * t_in[4][a];
         t_in[5][a]    = ONE_T - TRIG_W'(round_shift(RND_W'(prod_ff[4][a]), FRAC));
         prod_in[5][a] = yd_ff[4][a] * t_in[5][a];
         s_in[a]       = TRIG_W'(round_shift(RND_W'(prod_ff[5][a]), FRAC));
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_F1]) begin
         arg_ff <= arg_in;
      end
      if (stage_en[ST_F1+1]) begin
         y_ff <= y_in;
      end
      if (stage_en[ST_H0]) begin
         prod_ff[0] <= prod_in[0];
         yd_ff[0]   <= y_ff;
      end
      if (stage_en[ST_H0+1]) begin
         prod_ff[1] <= prod_in[1];
         x2_ff[1]   <= x2_in;
         yd_ff[1]   <= yd_ff[0];
      end
      if (stage_en[ST_H0+2]) begin
         prod_ff[2] <= prod_in[2];
         x2_ff[2]   <= x2_ff[1];
         yd_ff[2]   <= yd_ff[1];
      end
      if (stage_en[ST_H0+3]) begin
         prod_ff[3] <= prod_in[3];
         x2_ff[3]   <= x2_ff[2];
         yd_ff[3]   <= yd_ff[2];
      end
      if (stage_en[ST_H0+4]) begin
         prod_ff[4] <= prod_in[4];
         yd_ff[4]   <= yd_ff[3];
      end
      if (stage_en[ST_H0+5]) begin
         prod_ff[5] <= prod_in[5];
      end
      if (stage_en[ST_H0+6]) begin
         s_ff <= s_in;
      end
   end

   assign sin_value = s_ff[0];
   assign cos_value = s_ff[1];

endmodule

// ----- design/phase_lattice_site_update_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Phase lattice site update core
// One stochastic Euler step of a lattice site angle from its four neighbors.
// ----------------------------------------------------------------------------
//  Channel   Handshake             Payload
//  req       req_valid/req_stall   five angles, noise draw
//  rsp       rsp_valid/rsp_stall   new angle, saturated flag
//  csr       csr_write             csr_index, csr_data
//
// One transaction is accepted per cycle while req_stall is low. Synchronous
// reset clears only the valid bits and the configuration registers. A
// stalled result holds; empty stages keep filling.
// ----------------------------------------------------------------------------
module phase_lattice_site_update_core import plsu_pkg::*; #(
   parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF,
   parameter int NOISE_BITS  = NOISE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [ANGLE_WIDTH-1:0] req_center_angle,
   input  logic signed [ANGLE_WIDTH-1:0] req_up_angle,
   input  logic signed [ANGLE_WIDTH-1:0] req_down_angle,
   input  logic signed [ANGLE_WIDTH-1:0] req_left_angle,
   input  logic signed [ANGLE_WIDTH-1:0] req_right_angle,
   input  logic [NOISE_BITS:0]           req_noise_draw,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [ANGLE_WIDTH-1:0] rsp_new_angle,
   output logic                          rsp_saturated,
   input  logic                          csr_write,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CSR_W-1:0]              csr_data
);

   localparam int L      = lane_stages(ANGLE_WIDTH);
   localparam int DEPTH  = L + 5;
   localparam int NZ_W   = 34;
   localparam int RES_W  = ((ANGLE_WIDTH > DRIFT_W) ? ANGLE_WIDTH : DRIFT_W) + 2;
   localparam int PN_W   = NOISE_BITS + 34;
   localparam logic signed [NOISE_BITS+1:0] DRAW_MID =
      (NOISE_BITS + 2)'(longint'(1) << (NOISE_BITS - 1));
   localparam logic signed [TRIG_W+1:0] TWO_Q = (TRIG_W + 2)'(longint'(2) << FRAC);
   localparam logic signed [RES_W-1:0] HI_LIM =
      RES_W'((longint'(1) << (ANGLE_WIDTH - 1)) - 1);
   localparam logic signed [RES_W-1:0] LO_LIM = -HI_LIM - RES_W'(1);

   logic signed [31:0] coupling_x_ff, coupling_y_ff, curvature_x_ff, curvature_y_ff;
   logic [30:0]        time_step_ff, noise_gain_ff;

   logic [DEPTH-1:0] valid_ff;
   logic [DEPTH-1:0] en;

   logic signed [ANGLE_WIDTH-1:0] ctr_ff  [0:L+3];
   logic [NOISE_BITS:0]           draw_ff [0:L-1];

   logic signed [TRIG_W-1:0] sin_v [0:3];
   logic signed [TRIG_W-1:0] cos_v [0:3];

   logic signed [TRIG_W:0]        sx, sy;
   logic signed [TRIG_W+1:0]      cx, cy;
   logic signed [NOISE_BITS+1:0]  nv;
   logic signed [63:0]            p_ff [0:3];
   logic signed [PN_W-1:0]        pn_ff;
   logic signed [SUM_W-1:0]       r0, r1, r2, r3;
   logic signed [SUM_W-1:0]       sum_ff;
   logic signed [NZ_W-1:0]        noise_ff [0:2];
   logic signed [SUM_W-PP_LO+31:0] ph_ff;
   logic [PP_LO+30:0]             pl_ff;
   logic signed [RND_W-1:0]       pfull;
   logic signed [DRIFT_W-1:0]     drift_ff;
   logic signed [RES_W-1:0]       res;
   logic signed [ANGLE_WIDTH-1:0] out_angle_in, out_angle_ff;
   logic                          out_sat_in, out_sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coupling_x_ff  <= '0;
         coupling_y_ff  <= '0;
         curvature_x_ff <= '0;
         curvature_y_ff <= '0;
         time_step_ff   <= '0;
         noise_gain_ff  <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_COUPLING_X:  coupling_x_ff  <= csr_data;
            CSR_COUPLING_Y:  coupling_y_ff  <= csr_data;
            CSR_CURVATURE_X: curvature_x_ff <= csr_data;
            CSR_CURVATURE_Y: curvature_y_ff <= csr_data;
            CSR_TIME_STEP:   time_step_ff   <= csr_data[30:0];
            CSR_NOISE_GAIN:  noise_gain_ff  <= csr_data[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      en[DEPTH-1] = !valid_ff[DEPTH-1] || !rsp_stall;
      for (int s = DEPTH - 2; s >= 0; s--) begin
         en[s] = !valid_ff[s] || en[s+1];
      end
   end

   assign req_stall = !en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int s = 1; s < DEPTH; s++) begin
            if (en[s]) begin
               valid_ff[s] <= valid_ff[s-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         ctr_ff[0]  <= req_center_angle;
         draw_ff[0] <= req_noise_draw;
      end
      for (int s = 1; s < L + 4; s++) begin
         if (en[s]) begin
            ctr_ff[s] <= ctr_ff[s-1];
         end
      end
      for (int s = 1; s < L; s++) begin
         if (en[s]) begin
            draw_ff[s] <= draw_ff[s-1];
         end
      end
   end

   plsu_lane #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_lane_up (
      .clock(clock), .stage_en(en[L-1:0]), .center_angle(req_center_angle),
      .neighbor_angle(req_up_angle), .sin_value(sin_v[0]), .cos_value(cos_v[0]));
   plsu_lane #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_lane_down (
      .clock(clock), .stage_en(en[L-1:0]), .center_angle(req_center_angle),
      .neighbor_angle(req_down_angle), .sin_value(sin_v[1]), .cos_value(cos_v[1]));
   plsu_lane #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_lane_left (
      .clock(clock), .stage_en(en[L-1:0]), .center_angle(req_center_angle),
      .neighbor_angle(req_left_angle), .sin_value(sin_v[2]), .cos_value(cos_v[2]));
   plsu_lane #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_lane_right (
      .clock(clock), .stage_en(en[L-1:0]), .center_angle(req_center_angle),
      .neighbor_angle(req_right_angle), .sin_value(sin_v[3]), .cos_value(cos_v[3]));

   always_comb begin
      sx = sin_v[3] + sin_v[2];
      sy = sin_v[0] + sin_v[1];
      cx = cos_v[2] + cos_v[3] - TWO_Q;
      cy = cos_v[0] + cos_v[1] - TWO_Q;
      nv = $signed({1'b0, draw_ff[L-1]}) - DRAW_MID;
   end

   always_comb begin
      r0 = SUM_W'(round_shift(RND_W'(p_ff[0]), FRAC));
      r1 = SUM_W'(round_shift(RND_W'(p_ff[1]), FRAC));
      r2 = SUM_W'(round_shift(RND_W'(p_ff[2]), FRAC + 1));
      r3 = SUM_W'(round_shift(RND_W'(p_ff[3]), FRAC + 1));
      pfull = (RND_W'(ph_ff) <<< PP_LO) + $signed(RND_W'(pl_ff));
      res = RES_W'(ctr_ff[L+3]) + RES_W'(drift_ff) + RES_W'(noise_ff[2]);
      out_sat_in = 1'b1;
      priority if (res > HI_LIM) begin
         out_angle_in = HI_LIM[ANGLE_WIDTH-1:0];
      end else if (res < LO_LIM) begin
         out_angle_in = LO_LIM[ANGLE_WIDTH-1:0];
      end else begin
         out_angle_in = res[ANGLE_WIDTH-1:0];
         out_sat_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en[L]) begin
         p_ff[0] <= sx * coupling_x_ff;
         p_ff[1] <= sy * coupling_y_ff;
         p_ff[2] <= cx * curvature_x_ff;
         p_ff[3] <= cy * curvature_y_ff;
         pn_ff   <= nv * $signed({1'b0, noise_gain_ff});
      end
      if (en[L+1]) begin
         sum_ff      <= -r0 - r1 - r2 - r3;
         noise_ff[0] <= NZ_W'(round_shift(RND_W'(pn_ff), NOISE_BITS));
      end
      if (en[L+2]) begin
         ph_ff       <= $signed(sum_ff[SUM_W-1:PP_LO]) * $signed({1'b0, time_step_ff});
         pl_ff       <= sum_ff[PP_LO-1:0] * time_step_ff;
         noise_ff[1] <= noise_ff[0];
      end
      if (en[L+3]) begin
         drift_ff    <= DRIFT_W'(round_shift(pfull, FRAC));
         noise_ff[2] <= noise_ff[1];
      end
      if (en[L+4]) begin
         out_angle_ff <= out_angle_in;
         out_sat_ff   <= out_sat_in;
      end
   end

   assign rsp_valid     = valid_ff[DEPTH-1];
   assign rsp_new_angle = out_angle_ff;
   assign rsp_saturated = out_sat_ff;

endmodule

// ----- bench/phase_lattice_site_update_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Phase lattice site update core testbench
// Drives site transactions with random gaps and response stalls, predicts
// each new angle with a fixed-point trig model and checks every response.
// ----------------------------------------------------------------------------
module phase_lattice_site_update_core_tb import plsu_pkg::*; ();

   localparam int AW = 32;
   localparam int NB = 20;
   localparam longint ONE_Q = longint'(1) << FRAC;
   localparam longint C3 = 2796203;
   localparam longint C5 = 139810;
   localparam longint C7 = 3329;
   localparam longint C9 = 46;

   typedef struct packed {
      logic signed [AW-1:0] new_angle;
      logic                 saturated;
   } site_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [AW-1:0] req_center_angle = '0;
   logic signed [AW-1:0] req_up_angle = '0;
   logic signed [AW-1:0] req_down_angle = '0;
   logic signed [AW-1:0] req_left_angle = '0;
   logic signed [AW-1:0] req_right_angle = '0;
   logic [NB:0] req_noise_draw = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [AW-1:0] rsp_new_angle;
   logic rsp_saturated;
   logic csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0] csr_data = '0;

   longint coupling_x, coupling_y, curvature_x, curvature_y, time_step, noise_gain;
   site_result_type expected_angles[$];
   int errors = 0;
   int hold_off = 0;
   int stall_mode = 0;

   phase_lattice_site_update_core i_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Rounded product a*b/2^sh, ties away from zero.
   function automatic longint round_mul(longint a, longint b, int sh);
      logic signed [127:0] p;
      logic [127:0] m;
      p = 128'(a) * 128'(b);
      m = (p < 0) ? -p : p;
      m = (m + (128'(1) << (sh - 1))) >> sh;
      return (p < 0) ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint fixed_sin(longint d);
      longint x, x2, t;
      x = d % Q_TWO_PI;
      if (x < 0) x += Q_TWO_PI;
      if (x >= Q_PI) x -= Q_TWO_PI;
      if (x > Q_HALF_PI) x = Q_PI - x;
      else if (x < -Q_HALF_PI) x = -Q_PI - x;
      x2 = round_mul(x, x, FRAC);
      t = C9;
      t = C7 - round_mul(x2, t, FRAC);
      t = C5 - round_mul(x2, t, FRAC);
      t = C3 - round_mul(x2, t, FRAC);
      t = ONE_Q - round_mul(x2, t, FRAC);
      return round_mul(x, t, FRAC);
   endfunction

   function automatic site_result_type predict_site(longint c, longint u, longint dn,
                                                    longint l, longint r, longint draw);
      longint sx, sy, kx, ky, sum, res;
      site_result_type o;
      sx = fixed_sin(c - r) + fixed_sin(c - l);
      sy = fixed_sin(c - u) + fixed_sin(c - dn);
      kx = fixed_sin(c - l + Q_HALF_PI) + fixed_sin(c - r + Q_HALF_PI) - 2 * ONE_Q;
      ky = fixed_sin(c - u + Q_HALF_PI) + fixed_sin(c - dn + Q_HALF_PI) - 2 * ONE_Q;
      sum = -round_mul(sx, coupling_x, FRAC) - round_mul(sy, coupling_y, FRAC)
            - round_mul(kx, curvature_x, FRAC + 1) - round_mul(ky, curvature_y, FRAC + 1);
      res = c + round_mul(sum, time_step, FRAC)
            + round_mul(draw - (longint'(1) << (NB - 1)), noise_gain, NB);
      o.saturated = 1'b1;
      if (res > 64'sd2147483647) res = 64'sd2147483647;
      else if (res < -64'sd2147483648) res = -64'sd2147483648;
      else o.saturated = 1'b0;
      o.new_angle = AW'(res);
      return o;
   endfunction

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [31:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_COUPLING_X: coupling_x = longint'($signed(value));
         CSR_COUPLING_Y: coupling_y = longint'($signed(value));
         CSR_CURVATURE_X: curvature_x = longint'($signed(value));
         CSR_CURVATURE_Y: curvature_y = longint'($signed(value));
         CSR_TIME_STEP: time_step = longint'(value[30:0]);
         CSR_NOISE_GAIN: noise_gain = longint'(value[30:0]);
         default: ;
      endcase
   endtask

   // Sends one site transaction; valid stays high across back-to-back sends.
   task automatic send_site(logic [31:0] c, logic [31:0] u, logic [31:0] dn,
                            logic [31:0] l, logic [31:0] r, logic [NB:0] draw);
      req_valid <= 1'b1;
      req_center_angle <= c;
      req_up_angle <= u;
      req_down_angle <= dn;
      req_left_angle <= l;
      req_right_angle <= r;
      req_noise_draw <= draw;
      do @(posedge clock); while (req_stall);
      expected_angles.push_back(predict_site(longint'($signed(c)), longint'($signed(u)),
                                             longint'($signed(dn)), longint'($signed(l)),
                                             longint'($signed(r)), longint'(draw)));
      @(negedge clock);
   endtask

   task automatic pause_sender();
      int gap;
      gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_angles.size() != 0) @(negedge clock);
      repeat (25) @(negedge clock);
   endtask

   function automatic logic [31:0] rand_angle();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 200000000)) - 100000000);
         default: return 32'($signed($urandom_range(0, 40000000)) - 20000000);
      endcase
   endfunction

   function automatic logic [NB:0] rand_draw();
      if ($urandom_range(0, 9) == 0)
         return (NB + 1)'($urandom);
      return (NB + 1)'($urandom_range(0, 1 << NB));
   endfunction

   task automatic send_random_sites(int count);
      logic [31:0] c;
      repeat (count) begin
         c = rand_angle();
         if ($urandom_range(0, 1))
            send_site(c, c + 32'($signed($urandom_range(0, 8000000)) - 4000000),
                      c + 32'($signed($urandom_range(0, 8000000)) - 4000000),
                      c + 32'($signed($urandom_range(0, 8000000)) - 4000000),
                      c + 32'($signed($urandom_range(0, 8000000)) - 4000000),
                      rand_draw());
         else
            send_site(c, rand_angle(), rand_angle(), rand_angle(), rand_angle(),
                      rand_draw());
         pause_sender();
      end
   endtask

   task automatic random_config();
      write_register(CSR_COUPLING_X, 32'($signed($urandom_range(0, 67108864)) - 33554432));
      write_register(CSR_COUPLING_Y, 32'($signed($urandom_range(0, 67108864)) - 33554432));
      write_register(CSR_CURVATURE_X, 32'($signed($urandom_range(0, 67108864)) - 33554432));
      write_register(CSR_CURVATURE_Y, 32'($signed($urandom_range(0, 67108864)) - 33554432));
      write_register(CSR_TIME_STEP, $urandom_range(0, 8388608));
      write_register(CSR_NOISE_GAIN, $urandom_range(0, 33554432));
   endtask

   task automatic test_reset_defaults();
      send_site(32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h1234_5678, 32'hFFFF_FFFF, '0);
      send_site(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 1, (NB + 1)'(1 << NB));
      drain();
   endtask

   task automatic test_directed_extremes();
      write_register(CSR_COUPLING_X, 32'h7FFF_FFFF);
      write_register(CSR_COUPLING_Y, 32'h8000_0000);
      write_register(CSR_CURVATURE_X, 32'h8000_0000);
      write_register(CSR_CURVATURE_Y, 32'h7FFF_FFFF);
      write_register(CSR_TIME_STEP, 32'h7FFF_FFFF);
      write_register(CSR_NOISE_GAIN, 32'h7FFF_FFFF);
      write_register(3'd6, 32'hDEAD_BEEF);
      write_register(3'd7, 32'h1);
      send_site(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000, (NB + 1)'(1 << NB));
      send_site(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, '0);
      send_site(0, 32'(Q_PI), 32'(-Q_PI), 32'(Q_HALF_PI), 32'(-Q_HALF_PI),
                (NB + 1)'(1 << (NB - 1)));
      send_site(32'(Q_PI), 0, 32'(Q_TWO_PI), 32'(Q_PI + 1), 32'(Q_PI - 1), 21'h1F_FFFF);
      send_site(32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 32'h0100_0000,
                32'h0100_0000, 21'h10_0001);
      drain();
      write_register(CSR_TIME_STEP, 32'h0010_0000);
      write_register(CSR_NOISE_GAIN, 32'h0000_0000);
      send_site(32'h7FFF_0000, 32'h8000_0000, 32'h8100_0000, 32'h7000_0000, 32'h0, '0);
      send_site(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0, 21'h0A_AAAA);
      drain();
   endtask

   task automatic test_random_streams();
      repeat (4) begin
         random_config();
         send_random_sites(180);
         drain();
      end
   endtask

   task automatic test_backpressure();
      random_config();
      hold_off = 60;
      send_random_sites(60);
      drain();
   endtask

   always @(negedge clock) begin
      if (hold_off > 0) begin
         rsp_stall <= 1'b1;
         hold_off <= hold_off - 1;
      end else begin
         if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 1) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      site_result_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_angles.size() == 0) begin
            $error("unexpected transaction: new_angle %0d", rsp_new_angle);
            errors++;
         end else begin
            exp_r = expected_angles.pop_front();
            if (rsp_new_angle !== exp_r.new_angle) begin
               $error("new_angle expected %0d actual %0d", exp_r.new_angle, rsp_new_angle);
               errors++;
            end
            if (rsp_saturated !== exp_r.saturated) begin
               $error("saturated expected %0b actual %0b", exp_r.saturated, rsp_saturated);
               errors++;
            end
         end
      end
   end

   initial begin
      {coupling_x, coupling_y, curvature_x, curvature_y, time_step, noise_gain} = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_directed_extremes();
      test_random_streams();
      test_backpressure();
      if (errors == 0 && expected_angles.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #2ms;
      $display("Test completed with failures");
      $finish;
   end

endmodule

// ----- sim.f -----
design/plsu_pkg.sv
design/plsu_lane.sv
design/phase_lattice_site_update_core.sv
bench/phase_lattice_site_update_core_tb.sv
